@@ rtl/core/text_console_cursor_engine_assert.svh @@
// Assertion macros for the text console cursor engine.
// Included by the top level; depends on nothing else.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCE_ASSERT_NOW(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tcce_pkg.sv @@
// Shared types and constants of the text console cursor engine.
// Used by text_console_cursor_engine; depends on nothing else.
package tcce_pkg;

    // Drawing command codes.
    typedef enum logic [1:0] {
        CMD_FILL_CELL   = 2'd0,
        CMD_GLYPH       = 2'd1,
        CMD_SCROLL      = 2'd2,
        CMD_FILL_SCREEN = 2'd3
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ENABLE      = 3'd0,
        CFG_COLUMNS     = 3'd1,
        CFG_ROWS_COUNT  = 3'd2,
        CFG_FORE_COLOUR = 3'd3,
        CFG_BACK_COLOUR = 3'd4
    } cfg_index_t;

    // Control characters.
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [8:0] TAB_STEP = 9'd4;
    localparam logic [8:0] TAB_MASK = ~(TAB_STEP - 9'd1);

    // Register reset values.
    localparam logic [7:0]  RST_COLUMNS     = 8'd80;
    localparam logic [7:0]  RST_ROWS_COUNT  = 8'd25;
    localparam logic [31:0] RST_FORE_COLOUR = 32'hFFC8C8C8;
    localparam logic [31:0] RST_BACK_COLOUR = 32'hFF101418;

    // Most commands one item can cause.
    localparam int unsigned MAX_CMDS = 3;
    localparam logic [1:0]  MAX_CMDS_CNT = 2'd3;

    // Output tdata: 72 payload bits, already whole bytes.
    localparam int unsigned OUT_DATA_W = 72;

    // One drawing command waiting to go out.
    typedef struct packed {
        cmd_t        command;
        logic [7:0]  cell_col;
        logic [7:0]  cell_row;
        logic [7:0]  glyph;
        logic [31:0] colour;
    } cmd_entry_t;

endpackage

@@ rtl/core/text_console_cursor_engine.sv @@
// Top level of the text console cursor engine: cursor state, command builder
// and output serializer. Depends on tcce_pkg and text_console_cursor_engine_assert.svh.

// Each accepted item is decoded combinationally into zero to three drawing
// commands, which go into a small command buffer; the output register then
// sends them one per cycle while the receiver is ready. An item that causes
// several commands holds off the next item while the output register drains
// the buffer (a printable character with a scroll causes three). The next
// item is taken once the buffer is empty or its last command moves into the
// output register, even while that command then waits there. Items that
// arrive while enable is low are taken and dropped without touching the
// cursor. Configuration writes must happen while idle.
`include "text_console_cursor_engine_assert.svh"

module text_console_cursor_engine (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] op
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,   // [1:0] command
    // [7:0] cell_col, [15:8] cell_row, [23:16] glyph, [55:24] colour,
    // [63:56] cursor_col_after, [71:64] cursor_row_after
    output logic [tcce_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import tcce_pkg::*;

    // Configuration registers.
    logic        enable_reg;
    logic [7:0]  columns_reg;
    logic [7:0]  rows_count_reg;
    logic [31:0] fore_colour_reg;
    logic [31:0] back_colour_reg;

    // Cursor state.
    logic [7:0]  cursor_col_reg, cursor_col_next;
    logic [7:0]  cursor_row_reg, cursor_row_next;

    // Command buffer.
    cmd_entry_t  bundle_reg [MAX_CMDS];
    cmd_entry_t  bundle_next [MAX_CMDS];
    logic [1:0]  bundle_cnt_reg, bundle_cnt_next;
    logic [7:0]  bundle_col_reg, bundle_col_next;
    logic [7:0]  bundle_row_reg, bundle_row_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    cmd_entry_t  m_entry_reg, m_entry_next;
    logic [7:0]  m_col_after_reg, m_col_after_next;
    logic [7:0]  m_row_after_reg, m_row_after_next;
    logic        m_last_reg, m_last_next;

    // Decode results.
    logic [7:0]  cols_eff;
    logic [7:0]  rows_eff;
    logic [8:0]  col_w;
    logic [8:0]  row_w;
    cmd_entry_t  char_cmd [2];
    logic [1:0]  n_char;
    logic        scroll;
    cmd_entry_t  slot [MAX_CMDS];
    logic [1:0]  n_total;

    logic        out_load;
    logic        pop;
    logic        in_fire;
    logic        in_take;

    // Handshake.
    assign out_load      = !m_valid_reg || m_axis_tready;
    assign pop           = out_load && (bundle_cnt_reg != 2'd0);
    assign s_axis_tready = (bundle_cnt_reg == 2'd0) || ((bundle_cnt_reg == 2'd1) && out_load);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_take       = in_fire && enable_reg;

    // Decode one item into cursor movement and commands.
    always_comb
    begin
        cols_eff = (columns_reg == 8'd0) ? 8'd1 : columns_reg;
        rows_eff = (rows_count_reg == 8'd0) ? 8'd1 : rows_count_reg;
        col_w    = {1'b0, cursor_col_reg};
        row_w    = {1'b0, cursor_row_reg};
        n_char   = 2'd0;
        scroll   = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            char_cmd[i] = '{command: CMD_FILL_CELL, cell_col: 8'd0, cell_row: 8'd0,
                            glyph: 8'd0, colour: back_colour_reg};
        end

        if (s_axis_tuser)
        begin
            char_cmd[0].command = CMD_FILL_SCREEN;
            n_char = 2'd1;
            col_w  = 9'd0;
            row_w  = 9'd0;
        end
        else
        begin
            unique case (s_axis_tdata)
                CH_LF:
                begin
                    col_w = 9'd0;
                    row_w = row_w + 9'd1;
                end
                CH_CR:
                begin
                    col_w = 9'd0;
                end
                CH_BS:
                begin
                    if (col_w != 9'd0)
                    begin
                        col_w = col_w - 9'd1;
                        char_cmd[0].cell_col = col_w[7:0];
                        char_cmd[0].cell_row = row_w[7:0];
                        n_char = 2'd1;
                    end
                end
                CH_TAB:
                begin
                    col_w = (col_w + TAB_STEP) & TAB_MASK;
                    if (col_w >= {1'b0, cols_eff})
                    begin
                        col_w = 9'd0;
                        row_w = row_w + 9'd1;
                    end
                end
                default:
                begin
                    char_cmd[0].cell_col = col_w[7:0];
                    char_cmd[0].cell_row = row_w[7:0];
                    char_cmd[1] = '{command: CMD_GLYPH, cell_col: col_w[7:0],
                                    cell_row: row_w[7:0], glyph: s_axis_tdata,
                                    colour: fore_colour_reg};
                    n_char = (s_axis_tdata == CH_SPACE) ? 2'd1 : 2'd2;
                    col_w  = col_w + 9'd1;
                    if (col_w >= {1'b0, cols_eff})
                    begin
                        col_w = 9'd0;
                        row_w = row_w + 9'd1;
                    end
                end
            endcase

            // Past the last row: scroll and stay on the last row.
            if (row_w >= {1'b0, rows_eff})
            begin
                scroll = 1'b1;
                row_w  = {1'b0, rows_eff - 8'd1};
            end
        end

        cursor_col_next = col_w[7:0];
        cursor_row_next = row_w[7:0];
        n_total = n_char + {1'b0, scroll};

        // Place the character commands first and the scroll behind them.
        for (int i = 0; i < MAX_CMDS; i++)
        begin
            if (i < 2 && 2'(i) < n_char)
                slot[i] = char_cmd[(i < 2) ? i : 0];
            else
                slot[i] = '{command: CMD_SCROLL, cell_col: 8'd0, cell_row: 8'd0,
                            glyph: 8'd0, colour: back_colour_reg};
        end
    end

    // Command buffer: shift out on a pop, reload on a taken item.
    always_comb
    begin
        bundle_next     = bundle_reg;
        bundle_cnt_next = bundle_cnt_reg;
        bundle_col_next = bundle_col_reg;
        bundle_row_next = bundle_row_reg;
        if (pop)
        begin
            bundle_next[0]  = bundle_reg[1];
            bundle_next[1]  = bundle_reg[2];
            bundle_cnt_next = bundle_cnt_reg - 2'd1;
        end
        if (in_take)
        begin
            bundle_next     = slot;
            bundle_cnt_next = n_total;
            bundle_col_next = cursor_col_next;
            bundle_row_next = cursor_row_next;
        end
    end

    // Output register load.
    always_comb
    begin
        m_valid_next     = m_valid_reg;
        m_entry_next     = m_entry_reg;
        m_col_after_next = m_col_after_reg;
        m_row_after_next = m_row_after_reg;
        m_last_next      = m_last_reg;
        if (out_load)
        begin
            m_valid_next     = (bundle_cnt_reg != 2'd0);
            m_entry_next     = bundle_reg[0];
            m_col_after_next = bundle_col_reg;
            m_row_after_next = bundle_row_reg;
            m_last_next      = (bundle_cnt_reg == 2'd1);
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            columns_reg     <= RST_COLUMNS;
            rows_count_reg  <= RST_ROWS_COUNT;
            fore_colour_reg <= RST_FORE_COLOUR;
            back_colour_reg <= RST_BACK_COLOUR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:      enable_reg      <= cfg_data[0];
                CFG_COLUMNS:     columns_reg     <= cfg_data[7:0];
                CFG_ROWS_COUNT:  rows_count_reg  <= cfg_data[7:0];
                CFG_FORE_COLOUR: fore_colour_reg <= cfg_data;
                CFG_BACK_COLOUR: back_colour_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= 8'd0;
            cursor_row_reg <= 8'd0;
            bundle_cnt_reg <= 2'd0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                cursor_col_reg <= cursor_col_next;
                cursor_row_reg <= cursor_row_next;
            end
            bundle_cnt_reg <= bundle_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        bundle_reg      <= bundle_next;
        bundle_col_reg  <= bundle_col_next;
        bundle_row_reg  <= bundle_row_next;
        m_entry_reg     <= m_entry_next;
        m_col_after_reg <= m_col_after_next;
        m_row_after_reg <= m_row_after_next;
        m_last_reg      <= m_last_next;
    end

    // Output ports.
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_entry_reg.command;
    assign m_axis_tdata  = {m_row_after_reg, m_col_after_reg,
                            m_entry_reg.colour, m_entry_reg.glyph,
                            m_entry_reg.cell_row, m_entry_reg.cell_col};

    // Checks on the buffer and the cursor.
    `TCCE_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1,
        bundle_cnt_reg <= MAX_CMDS_CNT, "command buffer overflow")
    `TCCE_ASSERT_NEXT(a_burst_cont, clk, rst_n,
        m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid,
        "gap inside a command burst")
    `TCCE_ASSERT_NEXT(a_row_bound, clk, rst_n, in_take && !s_axis_tuser,
        cursor_row_reg != 8'd255, "cursor row past last row")
    `TCCE_ASSERT_NEXT(a_clear_home, clk, rst_n, in_take && s_axis_tuser,
        cursor_col_reg == 8'd0 && cursor_row_reg == 8'd0, "clear did not home cursor")

endmodule

@@ test/tb_text_console_cursor_engine.sv @@
// Self-checking testbench for the text console cursor engine.
// Predicts every drawing command from the cursor state and register values.
// Depends on tcce_pkg and the text_console_cursor_engine RTL.
`timescale 1ns / 100ps

module tb_text_console_cursor_engine;

    import tcce_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam int unsigned SETTLE      = 10;

    // One expected drawing command with the cursor position that follows it.
    typedef struct {
        cmd_t        command;
        logic [7:0]  cell_col;
        logic [7:0]  cell_row;
        logic [7:0]  glyph;
        logic [31:0] colour;
        logic [7:0]  col_after;
        logic [7:0]  row_after;
        logic        last_cmd;
    } draw_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_code
    logic        s_axis_tuser;   // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [1:0]  m_axis_tuser;   // [1:0] command
    // [7:0] cell_col, [15:8] cell_row, [23:16] glyph, [55:24] colour,
    // [63:56] cursor_col_after, [71:64] cursor_row_after
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Mirror of the registers and the cursor.
    logic        mir_enable;
    logic [7:0]  mir_columns;
    logic [7:0]  mir_rows;
    logic [31:0] mir_fore;
    logic [31:0] mir_back;
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;

    draw_cmd_t   cmd_expected_q[$];
    int          errors;
    int          items_sent;
    int          cmds_seen;
    int          burst_left;
    int          idle_cycles;
    bit          hold_req;

    text_console_cursor_engine DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic draw_cmd_t make_cmd(input cmd_t cmd, input int unsigned c,
                                           input int unsigned r, input logic [7:0] g,
                                           input logic [31:0] colour);
        draw_cmd_t d;
        d.command   = cmd;
        d.cell_col  = c[7:0];
        d.cell_row  = r[7:0];
        d.glyph     = g;
        d.colour    = colour;
        d.col_after = 8'd0;
        d.row_after = 8'd0;
        d.last_cmd  = 1'b0;
        return d;
    endfunction

    // Works out the commands of one accepted item and moves the cursor.
    function automatic void console_predict(input logic op, input logic [7:0] ch);
        int unsigned cols;
        int unsigned rows;
        int unsigned col;
        int unsigned row;
        draw_cmd_t   pend[$];
        cols = (mir_columns == 8'd0) ? 1 : mir_columns;
        rows = (mir_rows == 8'd0) ? 1 : mir_rows;
        col  = cur_col;
        row  = cur_row;
        if (!mir_enable)
            return;
        if (op)
        begin
            pend.push_back(make_cmd(CMD_FILL_SCREEN, 0, 0, 8'd0, mir_back));
            col = 0;
            row = 0;
        end
        else
        begin
            case (ch)
                CH_LF:
                begin
                    col = 0;
                    row++;
                end
                CH_CR:
                    col = 0;
                CH_BS:
                    if (col > 0)
                    begin
                        col--;
                        pend.push_back(make_cmd(CMD_FILL_CELL, col, row, 8'd0, mir_back));
                    end
                CH_TAB:
                begin
                    col = (col + 4) & ~32'd3;
                    if (col >= cols)
                    begin
                        col = 0;
                        row++;
                    end
                end
                default:
                begin
                    pend.push_back(make_cmd(CMD_FILL_CELL, col, row, 8'd0, mir_back));
                    if (ch != CH_SPACE)
                        pend.push_back(make_cmd(CMD_GLYPH, col, row, ch, mir_fore));
                    col++;
                    if (col >= cols)
                    begin
                        col = 0;
                        row++;
                    end
                end
            endcase
            // Running off the bottom scrolls and pins the cursor to the last row.
            if (row >= rows)
            begin
                pend.push_back(make_cmd(CMD_SCROLL, 0, 0, 8'd0, mir_back));
                row = rows - 1;
            end
        end
        cur_col = col[7:0];
        cur_row = row[7:0];
        foreach (pend[k])
        begin
            pend[k].col_after = cur_col;
            pend[k].row_after = cur_row;
            pend[k].last_cmd  = (k == pend.size() - 1);
            cmd_expected_q.push_back(pend[k]);
        end
    endfunction

    // Sends one item in bursts with random gaps between them.
    task automatic send_item(input logic op, input logic [7:0] ch);
        if (burst_left <= 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= ch;
        do
            @(posedge clk);
        while (!s_axis_tready);
        console_predict(op, ch);
        items_sent++;
        burst_left--;
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_item(1'b0, ch);
    endtask

    // Lets every expected command come out, then lets the bench settle.
    task automatic drain_console();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (cmd_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes one register and its mirror; callers may put random junk in bits above its width.
    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE:      mir_enable  = value[0];
            CFG_COLUMNS:     mir_columns = value[7:0];
            CFG_ROWS_COUNT:  mir_rows    = value[7:0];
            CFG_FORE_COLOUR: mir_fore    = value;
            CFG_BACK_COLOUR: mir_back    = value;
            default:         ;
        endcase
    endtask

    task automatic set_geometry(input logic [7:0] cols, input logic [7:0] rows);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_COLUMNS, {junk[31:8], cols});
        junk = $urandom;
        write_reg(CFG_ROWS_COUNT, {junk[31:8], rows});
    endtask

    task automatic set_enable(input logic en);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_ENABLE, {junk[31:1], en});
    endtask

    // Mostly random bytes, with control codes, spaces and clears mixed in.
    task automatic send_random_item();
        int unsigned pick;
        logic [7:0]  ch;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        if (pick < 4)
            send_item(1'b1, ch);
        else if (pick < 20)
        begin
            case ($urandom_range(0, 3))
                0:       send_char(CH_LF);
                1:       send_char(CH_CR);
                2:       send_char(CH_BS);
                default: send_char(CH_TAB);
            endcase
        end
        else if (pick < 30)
            send_char(CH_SPACE);
        else
            send_char(ch);
    endtask

    // After reset the console is disabled and drops everything.
    task automatic test_disabled_after_reset();
        send_char(8'h41);
        send_item(1'b1, 8'h00);
        send_char(CH_LF);
        drain_console();
    endtask

    // Reset geometry and colours are used once the console is enabled.
    task automatic test_default_geometry();
        set_enable(1'b1);
        send_char(8'h48);
        send_char(CH_SPACE);
        send_char(CH_TAB);
        drain_console();
    endtask

    // Every control code, byte extremes, wrap and scroll on a 4 by 2 screen.
    task automatic test_control_codes();
        set_geometry(8'd4, 8'd2);
        write_reg(CFG_FORE_COLOUR, 32'hFFFF_FFFF);
        write_reg(CFG_BACK_COLOUR, 32'h0000_0000);
        send_item(1'b1, 8'hFF);
        send_char(8'h41);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CH_SPACE);
        send_char(8'h80);
        send_char(CH_BS);
        send_char(CH_BS);
        send_char(CH_TAB);
        send_char(CH_CR);
        send_char(CH_TAB);
        send_char(CH_LF);
        drain_console();
    endtask

    // Zero columns and rows behave as a single cell.
    task automatic test_zero_geometry();
        set_geometry(8'd0, 8'd0);
        send_char(8'h5A);
        send_char(CH_TAB);
        send_char(CH_LF);
        drain_console();
    endtask

    // Shrinking the screen under the cursor still draws at the stored cell.
    task automatic test_cursor_beyond_geometry();
        set_geometry(8'd80, 8'd25);
        send_item(1'b1, 8'h00);
        send_char(CH_TAB);
        send_char(CH_TAB);
        send_char(CH_LF);
        send_char(CH_TAB);
        send_char(CH_TAB);
        drain_console();
        set_geometry(8'd2, 8'd1);
        send_char(8'h78);
        send_char(CH_BS);
        drain_console();
    endtask

    // The receiver holds off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        set_geometry(8'd4, 8'd1);
        hold_req   = 1'b1;
        burst_left = 40;
        repeat (30) send_char(8'($urandom_range(33, 126)));
        drain_console();
    endtask

    // Random items over several register settings, the extremes among them.
    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    set_geometry(8'd255, 8'd255);
                    write_reg(CFG_FORE_COLOUR, 32'h0000_0000);
                    write_reg(CFG_BACK_COLOUR, 32'hFFFF_FFFF);
                end
                1:       set_geometry(8'd1, 8'd1);
                2:       set_enable(1'b0);
                3:
                begin
                    set_enable(1'b1);
                    set_geometry(8'($urandom_range(1, 12)), 8'($urandom_range(1, 6)));
                end
                default:
                begin
                    set_geometry(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    write_reg(CFG_FORE_COLOUR, $urandom);
                    write_reg(CFG_BACK_COLOUR, $urandom);
                end
            endcase
            repeat ((phase == 2) ? 10 : 36) send_random_item();
            drain_console();
        end
    endtask

    // Receiver: ready patterns in phases, plus one long hold on request.
    initial
    begin : receiver
        int unsigned mode;
        int          phase_left;
        m_axis_tready = 1'b0;
        phase_left    = 0;
        mode          = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            if (phase_left <= 0)
            begin
                mode       = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            errors++;
        end
    endtask

    // Compares each output transfer with the oldest expected command.
    always @(posedge clk)
    begin : output_check
        draw_cmd_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            cmds_seen++;
            if (cmd_expected_q.size() == 0)
            begin
                $error("unexpected command transfer: tdata %0h", m_axis_tdata);
                errors++;
            end
            else
            begin
                e = cmd_expected_q.pop_front();
                check_field("command", 32'(e.command), 32'(m_axis_tuser));
                check_field("cell_col", 32'(e.cell_col), 32'(m_axis_tdata[7:0]));
                check_field("cell_row", 32'(e.cell_row), 32'(m_axis_tdata[15:8]));
                check_field("glyph", 32'(e.glyph), 32'(m_axis_tdata[23:16]));
                check_field("colour", e.colour, m_axis_tdata[55:24]);
                check_field("cursor_col_after", 32'(e.col_after),
                            32'(m_axis_tdata[63:56]));
                check_field("cursor_row_after", 32'(e.row_after),
                            32'(m_axis_tdata[71:64]));
                check_field("last", 32'(e.last_cmd), 32'(m_axis_tlast));
            end
        end
    end

    // Watchdog on cycles in which neither side moves a transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_ENABLE;
        cfg_data      = 32'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;
        hold_req      = 1'b0;
        errors        = 0;
        items_sent    = 0;
        cmds_seen     = 0;
        burst_left    = 0;
        mir_enable    = 1'b0;
        mir_columns   = RST_COLUMNS;
        mir_rows      = RST_ROWS_COUNT;
        mir_fore      = RST_FORE_COLOUR;
        mir_back      = RST_BACK_COLOUR;
        cur_col       = 8'd0;
        cur_row       = 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_after_reset();
        test_default_geometry();
        test_control_codes();
        test_zero_geometry();
        test_cursor_beyond_geometry();
        test_backpressure();
        test_random_settings();
        drain_console();

        if (cmd_expected_q.size() != 0)
        begin
            $error("%0d expected commands never arrived", cmd_expected_q.size());
            errors++;
        end
        $display("Run covered %0d input items and %0d drawing commands", items_sent, cmds_seen);
        $display("over control codes, wrap, scroll, clear, odd geometry and backpressure.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
